### design/line_map_binary_search_table_macros.svh
// assertion macros for the port-level checker file
`ifndef LINE_MAP_BINARY_SEARCH_TABLE_MACROS_SVH
`define LINE_MAP_BINARY_SEARCH_TABLE_MACROS_SVH

// clocked check, quiet while reset is asserted
`define LMBS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked check that also holds across reset
`define LMBS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### design/lmbs_pkg.sv
// shared types and constants for the line map breakpoint table
package lmbs_pkg;

    localparam int LMBS_TABLE_DEPTH = 1024;

    localparam int KEY_W  = 31;
    localparam int LINE_W = 31;
    localparam int FILE_W = 16;
    localparam int STAT_W = 2;

    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 48;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK           = 2'd0;
    localparam logic [STAT_W-1:0] ST_BEFORE_FIRST = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL         = 2'd2;

    typedef struct packed {
        logic [FILE_W-1:0] file;
        logic [LINE_W-1:0] line;
        logic [KEY_W-1:0]  key;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRST,
        S_PROBE,
        S_SUB,
        S_ADD,
        S_DONE
    } t_state;

endpackage

### design/lmbs_mem.sv
// breakpoint entry memory, one write port and one registered read port
module lmbs_mem
    import lmbs_pkg::*;
#(
    parameter int DEPTH = LMBS_TABLE_DEPTH,
    parameter int AW    = $clog2(LMBS_TABLE_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_entry        i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_entry        o_rd_data
);

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### design/line_map_binary_search_table.sv
// insert: the result passes through S_DONE into the output register, then S_IDLE takes the next
// lookup: one probe read of the entry memory per halving step, then S_SUB and S_ADD
// one item at a time, taken only in S_IDLE
// the next item is taken while a result still waits in the output register
// synchronous active-low reset empties the table; the entry memory is not cleared
module line_map_binary_search_table
    import lmbs_pkg::*;
#(
    parameter int TABLE_DEPTH = LMBS_TABLE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // internal_line[30:0], source_line[61:31], file_index[77:62], zero [79:78]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // operation[0]
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // found_file[15:0], found_line[46:16], zero [47]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // status[1:0]
    output logic [STAT_W-1:0]     m_axis_tuser
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    t_state r_state, n_state;

    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_lo, n_lo;
    logic [CW-1:0]     r_hi, n_hi;
    logic [CW-1:0]     r_mid, n_mid;
    logic [KEY_W-1:0]  r_key, n_key;
    t_entry            r_lo_ent, n_lo_ent;
    logic [KEY_W-1:0]  r_diff, n_diff;
    logic [STAT_W-1:0] r_status, n_status;
    logic [FILE_W-1:0] r_file, n_file;
    logic [LINE_W-1:0] r_line, n_line;

    logic              r_out_valid, n_out_valid;
    logic [STAT_W-1:0] r_out_status, n_out_status;
    logic [FILE_W-1:0] r_out_file, n_out_file;
    logic [LINE_W-1:0] r_out_line, n_out_line;

    logic              in_fire;
    logic              in_op;
    t_entry            in_ent;

    logic              mem_wr_en;
    logic              mem_rd_en;
    logic [AW-1:0]     mem_rd_addr;
    t_entry            mem_rd_data;

    // one halving step of the search
    logic              step_below;
    logic [CW-1:0]     step_lo, step_hi;
    t_entry            step_lo_ent;
    logic [CW:0]       step_sum;
    logic              step_more;
    logic [LINE_W:0]   add_sum;
    logic              out_free;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign in_op    = s_axis_tuser;
    assign in_ent   = t_entry'(s_axis_tdata[KEY_W+LINE_W+FILE_W-1:0]);
    assign out_free = !r_out_valid || m_axis_tready;

    lmbs_mem #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (in_ent),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    always_comb begin
        step_below  = r_key < mem_rd_data.key;
        step_lo     = r_lo;
        step_hi     = r_hi;
        step_lo_ent = r_lo_ent;
        if (r_state == S_FIRST) begin
            step_lo     = '0;
            step_hi     = r_count;
            step_lo_ent = mem_rd_data;
        end else if (step_below) begin
            step_hi = r_mid;
        end else begin
            step_lo     = r_mid;
            step_lo_ent = mem_rd_data;
        end
        step_sum  = {1'b0, step_lo} + {1'b0, step_hi};
        step_more = ({1'b0, step_lo} + (CW+1)'(1)) < {1'b0, step_hi};
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (in_op == OP_LOOKUP && r_count != '0) begin
                        n_state = S_FIRST;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_FIRST: begin
                if (step_below) begin
                    n_state = S_DONE;
                end else if (step_more) begin
                    n_state = S_PROBE;
                end else begin
                    n_state = S_SUB;
                end
            end
            S_PROBE: begin
                n_state = step_more ? S_PROBE : S_SUB;
            end
            S_SUB:   n_state = S_ADD;
            S_ADD:   n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_count      = r_count;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_mid        = r_mid;
        n_key        = r_key;
        n_lo_ent     = r_lo_ent;
        n_diff       = r_diff;
        n_status     = r_status;
        n_file       = r_file;
        n_line       = r_line;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_status = r_out_status;
        n_out_file   = r_out_file;
        n_out_line   = r_out_line;
        mem_wr_en    = 1'b0;
        mem_rd_en    = 1'b0;
        mem_rd_addr  = '0;
        add_sum      = {1'b0, r_lo_ent.line} + {1'b0, r_diff};
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_key  = in_ent.key;
                    n_file = '0;
                    n_line = '0;
                    if (in_op == OP_INSERT) begin
                        if (r_count == CW'(TABLE_DEPTH)) begin
                            n_status = ST_FULL;
                        end else begin
                            n_status  = ST_OK;
                            mem_wr_en = 1'b1;
                            n_count   = r_count + CW'(1);
                        end
                    end else if (r_count == '0) begin
                        n_status = ST_BEFORE_FIRST;
                    end else begin
                        mem_rd_en = 1'b1;
                    end
                end
            end
            S_FIRST, S_PROBE: begin
                n_lo        = step_lo;
                n_hi        = step_hi;
                n_lo_ent    = step_lo_ent;
                n_mid       = step_sum[CW:1];
                mem_rd_addr = n_mid[AW-1:0];
                mem_rd_en   = step_more;
                if (r_state == S_FIRST && step_below) begin
                    n_status = ST_BEFORE_FIRST;
                end
            end
            S_SUB: begin
                // query is never below the chosen key
                n_diff = r_key - r_lo_ent.key;
            end
            S_ADD: begin
                n_status = ST_OK;
                n_file   = r_lo_ent.file;
                n_line   = add_sum[LINE_W] ? '1 : add_sum[LINE_W-1:0];
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_file   = r_file;
                    n_out_line   = r_line;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_mid        <= n_mid;
        r_key        <= n_key;
        r_lo_ent     <= n_lo_ent;
        r_diff       <= n_diff;
        r_status     <= n_status;
        r_file       <= n_file;
        r_line       <= n_line;
        r_out_status <= n_out_status;
        r_out_file   <= n_out_file;
        r_out_line   <= n_out_line;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_line, r_out_file};
    assign m_axis_tuser  = r_out_status;

endmodule

### design/lmbs_chk.sv
// port-level checker for the breakpoint table, bound to the top level
`include "line_map_binary_search_table_macros.svh"

module lmbs_chk
    import lmbs_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [STAT_W-1:0]     m_axis_tuser
);

    // a stalled result keeps its contents
    `LMBS_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

    // no status code beyond table full
    `LMBS_ASSERT(a_status_code, m_axis_tvalid |-> m_axis_tuser == ST_OK || m_axis_tuser == ST_BEFORE_FIRST || m_axis_tuser == ST_FULL, "bad status code")

    // a failed item carries no file or line
    `LMBS_ASSERT(a_fail_zero, m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata == '0, "failed item with payload")

    // one item at a time: busy right after an input transfer
    `LMBS_ASSERT(a_busy_after_in, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "second item taken while busy")

    // reset drops any pending result
    `LMBS_ASSERT_ALWAYS(a_rst_out, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")

endmodule

bind line_map_binary_search_table lmbs_chk u_lmbs_chk (.*);

### tb/tb_line_map_binary_search_table.sv
// self-checking testbench for the breakpoint line map with binary-search lookup
`timescale 1ns / 1ps

module tb_line_map_binary_search_table;
    import lmbs_pkg::*;

    localparam int                TAIL_CYCLES = 16;
    localparam int                STALL_LIMIT = 3000;
    localparam int                HOLD_CYCLES = 300;
    localparam int                HOLD_AFTER  = 400;
    localparam logic [KEY_W-1:0]  KEY_MAX     = '1;
    localparam logic [LINE_W-1:0] LINE_MAX    = '1;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [FILE_W-1:0] file;
        logic [LINE_W-1:0] line;
    } t_answer;

    // mirror of the breakpoint table and the answers still owed by the block
    class line_map_tracker;
        logic [KEY_W-1:0]  keys  [LMBS_TABLE_DEPTH];
        logic [LINE_W-1:0] lines [LMBS_TABLE_DEPTH];
        logic [FILE_W-1:0] files [LMBS_TABLE_DEPTH];
        int unsigned       count;
        t_answer           pending_answers[$];
        int                errors;

        function new();
            count  = 0;
            errors = 0;
        endfunction

        function t_answer resolve_line(logic [KEY_W-1:0] query);
            t_answer           ans;
            int unsigned       lo;
            int unsigned       hi;
            int unsigned       mid;
            logic [KEY_W-1:0]  offset;
            logic [LINE_W:0]   sum;
            ans = '0;
            if (count == 0 || query < keys[0]) begin
                ans.status = ST_BEFORE_FIRST;
                return ans;
            end
            lo = 0;
            hi = count;
            // same halving even when keys went in out of order
            while (lo + 1 < hi) begin
                mid = (lo + hi) / 2;
                if (query < keys[mid]) begin
                    hi = mid;
                end else begin
                    lo = mid;
                end
            end
            offset     = query - keys[lo];
            sum        = {1'b0, lines[lo]} + {1'b0, offset};
            ans.status = ST_OK;
            ans.file   = files[lo];
            ans.line   = sum[LINE_W] ? LINE_MAX : sum[LINE_W-1:0];
            return ans;
        endfunction

        function void note_request(logic op, logic [KEY_W-1:0] key,
                                   logic [LINE_W-1:0] src, logic [FILE_W-1:0] file);
            t_answer ans;
            ans = '0;
            if (op == OP_INSERT) begin
                if (count >= LMBS_TABLE_DEPTH) begin
                    ans.status = ST_FULL;
                end else begin
                    keys[count]  = key;
                    lines[count] = src;
                    files[count] = file;
                    count++;
                end
            end else begin
                ans = resolve_line(key);
            end
            pending_answers.push_back(ans);
        endfunction

        function void check_reply(logic [STAT_W-1:0] status, logic [FILE_W-1:0] file,
                                  logic [LINE_W-1:0] line);
            t_answer want;
            if (pending_answers.size() == 0) begin
                $error("unexpected result: status %0d found_file %0d found_line %0d",
                       status, file, line);
                errors++;
                return;
            end
            want = pending_answers.pop_front();
            if (status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, status);
                errors++;
            end
            if (file !== want.file) begin
                $error("found_file: expected %0d, actual %0d", want.file, file);
                errors++;
            end
            if (line !== want.line) begin
                $error("found_line: expected %0d, actual %0d", want.line, line);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [STAT_W-1:0]     m_axis_tuser;

    line_map_tracker  breakpoints = new();
    logic [KEY_W-1:0] key_cursor;
    int unsigned      burst_left = 0;

    always #6 i_clk = ~i_clk;

    line_map_binary_search_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    task automatic send_item(input logic op, input logic [KEY_W-1:0] key,
                             input logic [LINE_W-1:0] src, input logic [FILE_W-1:0] file);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {2'b00, file, src, key};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        breakpoints.note_request(op, key, src, file);
    endtask

    // bursts of random length, sometimes running straight into the next one
    task automatic pace();
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (breakpoints.pending_answers.size() != 0) @(posedge i_clk);
    endtask

    task automatic random_insert();
        logic [KEY_W-1:0]  key;
        logic [LINE_W-1:0] src;
        logic [FILE_W-1:0] file;
        int unsigned       left;
        int unsigned       room;
        int unsigned       step;
        left = (breakpoints.count < LMBS_TABLE_DEPTH) ? LMBS_TABLE_DEPTH - breakpoints.count : 1;
        room = KEY_MAX - key_cursor;
        if ($urandom_range(0, 19) == 0) begin
            // occasional key out of order
            key = KEY_W'($urandom);
        end else begin
            step = $urandom_range(0, 2 * (room / left));
            if (step > room) begin
                step = room;
            end
            key        = key_cursor + KEY_W'(step);
            key_cursor = key;
        end
        case ($urandom_range(0, 9))
            0, 1:    src = LINE_MAX - LINE_W'($urandom_range(0, 1 << 20));
            2:       src = LINE_W'($urandom_range(0, 100));
            default: src = LINE_W'($urandom);
        endcase
        case ($urandom_range(0, 19))
            0:       file = '0;
            1:       file = '1;
            default: file = FILE_W'($urandom);
        endcase
        send_item(OP_INSERT, key, src, file);
    endtask

    task automatic random_lookup();
        logic [KEY_W-1:0] query;
        logic [31:0]      wide;
        int unsigned      idx;
        int unsigned      pick;
        pick = $urandom_range(0, 9);
        idx  = (breakpoints.count == 0) ? 0 : $urandom_range(0, breakpoints.count - 1);
        if (breakpoints.count == 0 || pick == 0) begin
            query = KEY_W'($urandom);
        end else begin
            case (pick)
                1:       query = (breakpoints.keys[0] == '0) ? '0 : breakpoints.keys[0] - 1'b1;
                2:       query = breakpoints.keys[idx];
                3:       query = (breakpoints.keys[idx] == '0) ? '0
                                                               : breakpoints.keys[idx] - 1'b1;
                4:       query = KEY_MAX;
                default: begin
                    wide  = 32'(breakpoints.keys[idx]) + $urandom_range(0, 1 << 21);
                    query = (wide > 32'(KEY_MAX)) ? KEY_MAX : wide[KEY_W-1:0];
                end
            endcase
        end
        // unused fields still toggle
        send_item(OP_LOOKUP, query, LINE_W'($urandom), FILE_W'($urandom));
    endtask

    initial begin : stimulus
        int unsigned i;
        bit          drained_mid;
        drained_mid = 1'b0;
        key_cursor  = 31'd3000;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table
        send_item(OP_LOOKUP, '0, '0, '0);
        send_item(OP_LOOKUP, KEY_MAX, LINE_MAX, '1);
        // first entry at the top of the line range, so offsets saturate
        send_item(OP_INSERT, 31'd1000, LINE_MAX, 16'hFFFF);
        send_item(OP_LOOKUP, 31'd999, '0, '0);
        send_item(OP_LOOKUP, 31'd1000, '0, '0);
        send_item(OP_LOOKUP, 31'd1500, '0, '0);
        send_item(OP_INSERT, 31'd2000, '0, '0);
        send_item(OP_LOOKUP, 31'd2000, '0, '0);
        send_item(OP_LOOKUP, 31'd2001, '0, '0);
        send_item(OP_LOOKUP, KEY_MAX, '0, '0);
        // repeated key, then a key below its predecessor
        send_item(OP_INSERT, 31'd2000, 31'd5, 16'd1234);
        send_item(OP_LOOKUP, 31'd2000, '0, '0);
        send_item(OP_INSERT, 31'd1500, 31'd77, 16'd5);
        send_item(OP_LOOKUP, 31'd1999, '0, '0);
        send_item(OP_LOOKUP, 31'd1600, '0, '0);
        send_item(OP_LOOKUP, '0, '0, '0);
        send_item(OP_INSERT, 31'd3000, 31'h5555_5555, 16'hAAAA);
        send_item(OP_LOOKUP, 31'd3001, 31'h2AAA_AAAA, 16'h5555);

        hold_until_drained();

        // fill the table with mostly ascending keys
        while (breakpoints.count < LMBS_TABLE_DEPTH) begin
            if (!drained_mid && breakpoints.count >= LMBS_TABLE_DEPTH / 2) begin
                drained_mid = 1'b1;
                hold_until_drained();
            end
            pace();
            if ($urandom_range(0, 4) != 0) begin
                random_insert();
            end else begin
                random_lookup();
            end
        end

        // full table: inserts are dropped
        send_item(OP_INSERT, KEY_MAX, LINE_MAX, '1);
        send_item(OP_INSERT, '0, '0, '0);
        for (i = 0; i < 150; i++) begin
            pace();
            if ($urandom_range(0, 9) < 3) begin
                random_insert();
            end else begin
                random_lookup();
            end
        end

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (breakpoints.pending_answers.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (breakpoints.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin : result_sink
        int unsigned results;
        int unsigned hold_left;
        int unsigned rx_mode;
        int unsigned rx_mode_left;
        int unsigned phase;
        bit          held;
        results      = 0;
        hold_left    = 0;
        rx_mode      = 0;
        rx_mode_left = 0;
        phase        = 0;
        held         = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                breakpoints.check_reply(m_axis_tuser, m_axis_tdata[FILE_W-1:0],
                                        m_axis_tdata[FILE_W +: LINE_W]);
                results++;
            end
            phase++;
            if (hold_left != 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (!held && results == HOLD_AFTER) begin
                // long back-pressure so the block fills and stalls its input
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else begin
                if (rx_mode_left == 0) begin
                    rx_mode      = $urandom_range(0, 3);
                    rx_mode_left = $urandom_range(8, 64);
                end
                rx_mode_left--;
                case (rx_mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       m_axis_tready <= (phase % 4 == 0);
                    default: m_axis_tready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
